FILE: rtl/core/cleb_pkg.sv
package cleb_pkg;

	localparam int unsigned CHAR_W = 8;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_LEFT   = 3'd1,
		ACT_RIGHT  = 3'd2,
		ACT_BACK   = 3'd3,
		ACT_EOL    = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [CHAR_W-1:0] key;
	} key_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              has_char;
		logic              last;
		logic              overflowed;
	} line_word_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CHAR_W-1:0] key;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} state_t;

endpackage

FILE: rtl/core/cursor_line_edit_buffer_unit.sv
// Keystroke line editor. The line sits in a row of LINE_DEPTH character
// cells in display order; a cursor count marks the split. Insert and
// backspace shift the cells at and after the cursor by one place, cursor
// moves only change the count, so no edit word stalls the key input.
// An end-of-line word is taken the same way; after it the row shifts toward
// cell 0 and one character is emitted per cycle while the output is not
// stalled (an empty line gives one word with no character); no key
// word is taken until the cycle after the last character has gone into the
// output register. Inserts into a full line are dropped and set a sticky
// overflow flag, cleared only by reset.
module cursor_line_edit_buffer_unit import cleb_pkg::*; #(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_valid,
	output logic       key_stall,
	input  key_word_t  key_word,
	output logic       line_valid,
	input  logic       line_stall,
	output line_word_t line_word
);

	localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	state_t        state_q, state_d;
	logic [CW-1:0] cursor_q, total_q;
	logic          ovf_q;
	logic          out_valid_q;
	line_word_t    out_q;

	cell_ctl_t         ctl;
	logic              take, out_free, emit;
	logic [CHAR_W-1:0] cell_q [LINE_DEPTH];

	assign out_free = !out_valid_q || !line_stall;
	assign take     = key_valid && !key_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && key_word.action == ACT_EOL) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free && total_q <= ONE_C) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		key_stall = 1'b1;
		emit      = 1'b0;
		ctl.op    = CELL_HOLD;
		ctl.key   = key_word.key;
		case (state_q)
			ST_IDLE: begin
				key_stall = 1'b0;
				if (take) begin
					if (key_word.action == ACT_INSERT && total_q < DEPTH_C) begin
						ctl.op = CELL_INS;
					end else if (key_word.action == ACT_BACK && cursor_q != '0) begin
						ctl.op = CELL_DEL;
					end
				end
			end
			ST_FLUSH: begin
				emit = out_free;
				if (out_free) begin
					ctl.op = CELL_SHIFT;
				end
			end
			default: key_stall = 1'b1;
		endcase
	end

	for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
		logic [CHAR_W-1:0] lft, rgt;
		if (g == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid
			assign lft = cell_q[g-1];
		end
		if (g == LINE_DEPTH - 1) begin : g_end
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = cell_q[g+1];
		end
		cleb_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cursor     (cursor_q),
			.from_left  (lft),
			.from_right (rgt),
			.ch         (cell_q[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cursor_q    <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!line_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				case (key_word.action)
					ACT_INSERT: begin
						if (total_q < DEPTH_C) begin
							cursor_q <= cursor_q + ONE_C;
							total_q  <= total_q + ONE_C;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					ACT_LEFT: begin
						if (cursor_q != '0) begin
							cursor_q <= cursor_q - ONE_C;
						end
					end
					ACT_RIGHT: begin
						if (cursor_q < total_q) begin
							cursor_q <= cursor_q + ONE_C;
						end
					end
					ACT_BACK: begin
						if (cursor_q != '0) begin
							cursor_q <= cursor_q - ONE_C;
							total_q  <= total_q - ONE_C;
						end
					end
					default: cursor_q <= cursor_q;
				endcase
			end else if (emit) begin
				if (total_q <= ONE_C) begin
					total_q  <= '0;
					cursor_q <= '0;
				end else begin
					total_q <= total_q - ONE_C;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.ch         <= (total_q == '0) ? '0 : cell_q[0];
			out_q.has_char   <= (total_q != '0);
			out_q.last       <= (total_q <= ONE_C);
			out_q.overflowed <= ovf_q;
		end
	end

	assign line_valid = out_valid_q;
	assign line_word  = out_q;

endmodule

FILE: rtl/core/cleb_cell.sv
module cleb_cell import cleb_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CW-1:0]     cursor,
	input  logic [CHAR_W-1:0] from_left,
	input  logic [CHAR_W-1:0] from_right,
	output logic [CHAR_W-1:0] ch
);

	localparam logic [CW-1:0] POS      = CW'(IDX);
	localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

	logic [CHAR_W-1:0] ch_q;
	logic [CHAR_W-1:0] ch_d;

	always_comb begin
		ch_d = ch_q;
		case (ctl.op)
			CELL_INS: begin
				if (POS == cursor) begin
					ch_d = ctl.key;
				end else if (POS > cursor) begin
					ch_d = from_left;
				end
			end
			// backspace: cells from cursor-1 upward close the gap
			CELL_DEL: begin
				if (POS_NEXT >= cursor) begin
					ch_d = from_right;
				end
			end
			CELL_SHIFT: ch_d = from_right;
			default:    ch_d = ch_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ch_q <= ch_d;
	end

	assign ch = ch_q;

endmodule
